>>> rtl/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, ant, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ant, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/b64d_pkg.sv
// Package with types, codes and the alphabet lookup of the Base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

	localparam logic [6:0] SYM_BAD     = 7'd127;
	localparam logic [6:0] SYM_PAD     = 7'd64;
	localparam logic [5:0] SEXTET_MASK = 6'h3F;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [15:0] CNT_MAX    = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_SMALL   = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  nbytes;
		logic        has_status;
		status_t     status;
		logic [15:0] length;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
	} res_bundle_t;

	// Maps one character to its sextet, to SYM_PAD for '=' or to SYM_BAD.
	function automatic logic [6:0] sym_value(input logic [7:0] c);
		logic [6:0] v;
		v = SYM_BAD;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = 7'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = 7'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 7'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			v = 7'd62;
		end else if (c == 8'h2F) begin
			v = 7'd63;
		end else if (c == 8'h3D) begin
			v = SYM_PAD;
		end
		return v;
	endfunction

endpackage

>>> rtl/base64_stream_decoder_core.sv
// Top level of the streaming Base64 decoder.
//
// The input channel takes one character per request on ch, with last_char
// marking the final character of a text. The output channel gives decoded
// bytes (is_status low) and, after the final character, one status request
// with the status code and the count of bytes emitted; last marks the final
// result caused by each character. Bytes leave before the status is known,
// so a receiver drops them when the status reports an error.
// The capacity for the too-small check is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, which the
// block does not enforce. It resets to 65535. An accepted character is held in
// the input register, decoded and loaded into the result register, which drives
// the output. Throughput is one character per cycle while each character gives
// at most one result and the receiver does not stall; a character that completes
// a quartet holds the result register until each of its bytes is taken, and the
// final character until its status is taken too. When the receiver stalls, the
// result register and then the input register fill and in_ready drops. Reset
// clears the decode state, the pending results and the input register.
`timescale 1ns / 1ps

module base64_stream_decoder_core
	import b64d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        last_char,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_status,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic [15:0] decoded_length,
	output logic        last
);

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        last_s1;
	logic        fire;
	res_bundle_t bundle;

	b64d_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.last_char (last_char),
		.take      (fire),
		.valid_s1  (valid_s1),
		.ch_s1     (ch_s1),
		.last_s1   (last_s1)
	);

	b64d_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fire        (fire),
		.ch_s1       (ch_s1),
		.last_s1     (last_s1),
		.bundle      (bundle)
	);

	b64d_out_stage u_out_stage (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.bundle         (bundle),
		.fire           (fire),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.is_status      (is_status),
		.out_byte       (out_byte),
		.status         (status),
		.decoded_length (decoded_length),
		.last           (last)
	);

endmodule

>>> rtl/b64d_in_stage.sv
// Input register stage that holds one accepted character until the decoder takes it.
`timescale 1ns / 1ps

module b64d_in_stage
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       last_char,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] ch_s1,
	output logic       last_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= ch;
			last_s1 <= last_char;
		end
	end

endmodule

>>> rtl/b64d_decode.sv
// Decoder state, capacity register and the per-character decode logic.
`timescale 1ns / 1ps

module b64d_decode
	import b64d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        fire,
	input  logic [7:0]  ch_s1,
	input  logic        last_s1,
	output res_bundle_t bundle
);

	logic [15:0] capacity_q;
	logic [23:0] acc_q, acc_n;
	logic [1:0]  pos_q, pos_n;
	logic [1:0]  pad_q, pad_n;
	logic        pcr_q, pcr_n;
	logic        err_q, err_n;
	logic [15:0] sym_q, sym_n;
	logic [15:0] emit_q, emit_n;
	logic [6:0]  v;
	logic        skip;
	logic        take_sym;
	logic        accept;
	logic [1:0]  nb;
	logic [17:0] emit_sum;
	logic [18:0] need_sum;
	logic [15:0] need;
	status_t     st;

	always_comb begin
		acc_n    = acc_q;
		pos_n    = pos_q;
		pad_n    = pad_q;
		pcr_n    = pcr_q;
		err_n    = err_q;
		sym_n    = sym_q;
		skip     = 1'b0;
		take_sym = 1'b0;
		accept   = 1'b0;
		nb       = 2'd0;
		v        = sym_value(ch_s1);

		if (!err_q) begin
			if (pcr_q) begin
				pcr_n = 1'b0;
				if (ch_s1 == CHAR_LF) begin
					skip = 1'b1;
				end else begin
					err_n = 1'b1;
				end
			end
			if (!skip && !err_n) begin
				if (ch_s1 == CHAR_CR) begin
					pcr_n = 1'b1;
				end else if (ch_s1 != CHAR_LF) begin
					take_sym = 1'b1;
				end
			end
		end

		if (take_sym) begin
			if (v == SYM_BAD) begin
				err_n = 1'b1;
			end else if (v == SYM_PAD) begin
				if (pad_q >= 2'd2) begin
					err_n = 1'b1;
				end else begin
					pad_n  = pad_q + 2'd1;
					accept = 1'b1;
				end
			end else if (pad_q != 2'd0) begin
				err_n = 1'b1;
			end else begin
				accept = 1'b1;
			end
		end

		if (accept) begin
			if (sym_q != CNT_MAX) begin
				sym_n = sym_q + 16'd1;
			end
			acc_n = {acc_q[17:0], v[5:0] & SEXTET_MASK};
			pos_n = pos_q + 2'd1;
			if (pos_n == 2'd0) begin
				nb = 2'd3 - pad_n;
			end
		end

		emit_sum = {2'b00, emit_q} + {16'd0, nb};
		emit_n   = (emit_sum[17:16] != 2'b00) ? CNT_MAX : emit_sum[15:0];

		if (last_s1 && pcr_n) begin
			err_n = 1'b1;
		end

		need_sum = ({3'b000, sym_n} << 2) + ({3'b000, sym_n} << 1) + 19'd7;
		need     = need_sum[18:3];

		if (err_n) begin
			st = ST_INVALID;
		end else if (sym_n != 16'd0 && need > capacity_q) begin
			st = ST_SMALL;
		end else begin
			st = ST_OK;
		end

		bundle.nbytes     = nb;
		bundle.has_status = last_s1;
		bundle.status     = st;
		bundle.length     = emit_n;
		bundle.b0         = acc_n[23:16];
		bundle.b1         = acc_n[15:8];
		bundle.b2         = acc_n[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CNT_MAX;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pos_q  <= '0;
			pad_q  <= '0;
			pcr_q  <= 1'b0;
			err_q  <= 1'b0;
			sym_q  <= '0;
			emit_q <= '0;
		end else if (fire) begin
			if (last_s1) begin
				acc_q  <= '0;
				pos_q  <= '0;
				pad_q  <= '0;
				pcr_q  <= 1'b0;
				err_q  <= 1'b0;
				sym_q  <= '0;
				emit_q <= '0;
			end else begin
				acc_q  <= acc_n;
				pos_q  <= pos_n;
				pad_q  <= pad_n;
				pcr_q  <= pcr_n;
				err_q  <= err_n;
				sym_q  <= sym_n;
				emit_q <= emit_n;
			end
		end
	end

endmodule

>>> rtl/b64d_out_stage.sv
// Result register that holds the results of one character and hands them out one at a time.
`timescale 1ns / 1ps

module b64d_out_stage
	import b64d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  res_bundle_t bundle,
	output logic        fire,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_status,
	output logic [7:0]  out_byte,
	output logic [1:0]  status,
	output logic [15:0] decoded_length,
	output logic        last
);

	res_bundle_t buf_q;
	logic        full_q;
	logic [1:0]  idx_q;
	logic [2:0]  total_q;
	logic [2:0]  total_in;
	logic        last_out;
	logic        load_ok;
	logic        load;
	logic        cur_status;
	logic [7:0]  cur_byte;

	assign total_q  = {1'b0, buf_q.nbytes} + {2'b00, buf_q.has_status};
	assign total_in = {1'b0, bundle.nbytes} + {2'b00, bundle.has_status};
	assign last_out = ({1'b0, idx_q} + 3'd1) == total_q;
	assign load_ok  = !full_q || (out_ready && last_out);
	assign fire     = valid_s1 && load_ok;
	assign load     = fire && (total_in != 3'd0);

	always_comb begin
		case (idx_q)
			2'd0:    cur_byte = buf_q.b0;
			2'd1:    cur_byte = buf_q.b1;
			default: cur_byte = buf_q.b2;
		endcase
	end

	assign cur_status     = buf_q.has_status && (idx_q == buf_q.nbytes);
	assign out_valid      = full_q;
	assign is_status      = cur_status;
	assign out_byte       = cur_status ? 8'd0 : cur_byte;
	assign status         = cur_status ? buf_q.status : ST_OK;
	assign decoded_length = cur_status ? buf_q.length : 16'd0;
	assign last           = last_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			full_q <= 1'b1;
			idx_q  <= '0;
		end else if (full_q && out_ready) begin
			if (last_out) begin
				full_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= bundle;
		end
	end

endmodule

>>> rtl/b64d_checker.sv
// Port-level checker of the Base64 stream decoder and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64d_checker
	import b64d_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        is_status,
	input logic [7:0]  out_byte,
	input logic [1:0]  status,
	input logic [15:0] decoded_length,
	input logic        last
);

	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "Output request dropped while stalled")
	`ASSERT_SAME(a_status_last, out_valid && is_status, last, "Status request is not the last result")
	`ASSERT_SAME(a_status_byte, out_valid && is_status, out_byte == 8'd0, "Status request carries a byte")
	`ASSERT_SAME(a_data_clean, out_valid && !is_status, status == ST_OK && decoded_length == 16'd0, "Data request carries status fields")
	`ASSERT_SAME(a_status_code, out_valid && is_status, status == ST_OK || status == ST_INVALID || status == ST_SMALL, "Unknown status code")

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.is_status      (is_status),
	.out_byte       (out_byte),
	.status         (status),
	.decoded_length (decoded_length),
	.last           (last)
);

>>> verif/base64_stream_decoder_core_test.sv
// Testbench of the Base64 stream decoder: a directed table, then random texts checked by a predictor.
`timescale 1ns / 1ps

module base64_stream_decoder_core_test;
	import b64d_pkg::*;

	localparam int RANDOM_ITEMS = 460;
	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic        is_status;
		logic [7:0]  out_byte;
		status_t     status;
		logic [15:0] decoded_length;
		logic        last;
	} result_t;

	typedef enum logic {ROW_CHAR, ROW_CAPACITY} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  c;
		logic        fin;
		logic        typed;
		status_t     st;
		logic [15:0] len;
		logic [15:0] cap;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  ch;
	logic        last_char;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        out_valid;
	logic        out_ready;
	logic        is_status;
	logic [7:0]  out_byte;
	logic [1:0]  status;
	logic [15:0] decoded_length;
	logic        last;

	logic [15:0] capacity = CNT_MAX;
	logic [23:0] sextets = '0;
	logic [1:0]  quartet_fill = '0;
	logic [1:0]  pad_count = '0;
	logic        cr_waiting = 1'b0;
	logic        text_broken = 1'b0;
	logic [15:0] symbols = '0;
	logic [15:0] bytes_out = '0;

	result_t     expected_results[$];
	result_t     fresh[$];
	logic [7:0]  text_chars[$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int          random_sent = 0;
	logic        idle_on = 1'b1;
	logic        stall_hold = 1'b0;

	stim_row_t directed_rows [27] = '{
		'{ROW_CHAR, CHAR_LF, 1'b1, 1'b1, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "T", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "W", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "F", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "u", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, CHAR_CR, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, CHAR_LF, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "Q", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "Q", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "=", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "=", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "=", 1'b1, 1'b1, ST_INVALID, 16'd4, 16'd0},
		'{ROW_CHAR, "/", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "/", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "/", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "/", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "A", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "=", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "B", 1'b1, 1'b1, ST_INVALID, 16'd3, 16'd0},
		'{ROW_CHAR, CHAR_CR, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "A", 1'b1, 1'b1, ST_INVALID, 16'd0, 16'd0},
		'{ROW_CHAR, 8'hFF, 1'b1, 1'b1, ST_INVALID, 16'd0, 16'd0},
		'{ROW_CAPACITY, 8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "T", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "W", 1'b0, 1'b0, ST_OK, 16'd0, 16'd0},
		'{ROW_CHAR, "F", 1'b1, 1'b1, ST_SMALL, 16'd0, 16'd0},
		'{ROW_CAPACITY, 8'h00, 1'b0, 1'b0, ST_OK, 16'd0, 16'hFFFF}
	};

	base64_stream_decoder_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.ch             (ch),
		.last_char      (last_char),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.is_status      (is_status),
		.out_byte       (out_byte),
		.status         (status),
		.decoded_length (decoded_length),
		.last           (last)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] alpha_char(input int v);
		if (v < 26) begin
			return 8'("A" + v);
		end else if (v < 52) begin
			return 8'("a" + v - 26);
		end else if (v < 62) begin
			return 8'("0" + v - 52);
		end else if (v == 62) begin
			return "+";
		end
		return "/";
	endfunction

	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		for (int v = 0; v < 64; v++) begin
			if (alpha_char(v) == c) begin
				return 7'(v);
			end
		end
		return (c == "=") ? SYM_PAD : SYM_BAD;
	endfunction

	task automatic decode_char(input logic [7:0] c, input logic fin);
		logic [6:0] v;
		logic       skip;
		int         need;
		result_t    r;
		fresh.delete();
		if (!text_broken) begin
			skip = 1'b0;
			if (cr_waiting) begin
				cr_waiting = 1'b0;
				if (c == CHAR_LF) skip = 1'b1;
				else text_broken = 1'b1;
			end
			if (!skip && !text_broken) begin
				if (c == CHAR_CR) begin
					cr_waiting = 1'b1;
				end else if (c != CHAR_LF) begin
					v = sextet_of(c);
					if (v == SYM_BAD || (v == SYM_PAD && pad_count >= 2) ||
							(v != SYM_PAD && pad_count != 0)) begin
						text_broken = 1'b1;
					end else begin
						if (v == SYM_PAD) pad_count++;
						if (symbols != CNT_MAX) symbols++;
						sextets = {sextets[17:0], v[5:0] & SEXTET_MASK};
						quartet_fill++;
						if (quartet_fill == 2'd0) begin
							for (int i = 0; i < 3 - int'(pad_count); i++) begin
								r = '0;
								r.out_byte = 8'(sextets >> (16 - 8 * i));
								fresh.push_back(r);
								if (bytes_out != CNT_MAX) bytes_out++;
							end
						end
					end
				end
			end
		end
		if (fin) begin
			r = '0;
			r.is_status = 1'b1;
			r.decoded_length = bytes_out;
			need = (int'(symbols) * 6 + 7) >> 3;
			if (cr_waiting || text_broken) r.status = ST_INVALID;
			else if (symbols != 0 && need > int'(capacity)) r.status = ST_SMALL;
			else r.status = ST_OK;
			fresh.push_back(r);
			sextets = '0;
			quartet_fill = '0;
			pad_count = '0;
			cr_waiting = 1'b0;
			text_broken = 1'b0;
			symbols = '0;
			bytes_out = '0;
		end
		if (fresh.size() > 0) fresh[$].last = 1'b1;
	endtask

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatches < 100) begin
			$display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
		end
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	task automatic send_char(input logic [7:0] c, input logic fin);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		last_char <= fin;
		do @(posedge clk); while (!in_ready);
		decode_char(c, fin);
		foreach (fresh[i]) expected_results.push_back(fresh[i]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity = value;
	endtask

	task automatic make_text();
		int         nq;
		int         pads;
		logic [7:0] c;
		text_chars.delete();
		nq = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
		for (int q = 0; q < nq; q++) begin
			pads = (q == nq - 1) ? $urandom_range(0, 2) : 0;
			for (int s = 0; s < 4; s++) begin
				c = (s >= 4 - pads) ? 8'("=") : alpha_char($urandom_range(0, 63));
				text_chars.push_back(c);
				if ($urandom_range(0, 19) == 0) begin
					if ($urandom_range(0, 1) == 0) text_chars.push_back(CHAR_CR);
					text_chars.push_back(CHAR_LF);
				end
			end
		end
		case ($urandom_range(0, 9))
			0: begin
				repeat ($urandom_range(1, 3)) text_chars.push_back(alpha_char($urandom_range(0, 63)));
			end
			1: begin
				text_chars.insert($urandom_range(0, text_chars.size()), 8'($urandom_range(0, 255)));
			end
			2: begin
				text_chars.insert($urandom_range(0, text_chars.size()), CHAR_CR);
			end
			3: begin
				if ($urandom_range(0, 1) == 0) text_chars.push_back(CHAR_CR);
				text_chars.push_back(CHAR_LF);
			end
			4: begin
				text_chars.push_back("=");
			end
			default: begin
			end
		endcase
		if (text_chars.size() == 0) text_chars.push_back(CHAR_LF);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("base64_stream_decoder_core verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, out_byte", 16'(out_byte), 16'd0);
			end else begin
				want = expected_results.pop_front();
				check_field("is_status", 16'(is_status), 16'(want.is_status));
				check_field("out_byte", 16'(out_byte), 16'(want.out_byte));
				check_field("status", 16'(status), 16'(want.status));
				check_field("decoded_length", decoded_length, want.decoded_length);
				check_field("last", 16'(last), 16'(want.last));
			end
		end
	end

	initial begin : receiver
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (stall_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				stall_hold = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : sender
		logic [15:0] cap;
		int          phase_target;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = '0;
		last_char = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CAPACITY) begin
				write_capacity(directed_rows[i].cap);
			end else begin
				send_char(directed_rows[i].c, directed_rows[i].fin);
				if (directed_rows[i].typed) begin
					expected_results[$] = '{1'b1, 8'd0, directed_rows[i].st,
						directed_rows[i].len, 1'b1};
				end
			end
		end

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: cap = 16'hFFFF;
				1: cap = 16'd0;
				2: cap = 16'($urandom_range(0, 24));
				3: cap = 16'd1;
				4: cap = 16'($urandom_range(0, 65535));
				5: cap = 16'($urandom_range(4, 16));
				6: cap = 16'($urandom_range(0, 24));
				default: cap = 16'hFFFF;
			endcase
			write_capacity(cap);
			idle_on = (p != 3) && (p != 7);
			if (p == 2) stall_hold = 1'b1;
			phase_target = RANDOM_ITEMS * (p + 1) / 8;
			while (random_sent < phase_target) begin
				make_text();
				foreach (text_chars[i]) begin
					send_char(text_chars[i], i == text_chars.size() - 1);
					random_sent++;
				end
				// In this phase the sender waits after each text until every result is back.
				if (p == 4 && random_sent < phase_target) begin
					wait_drained();
				end
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("base64_stream_decoder_core verification clean");
		end else begin
			$display("base64_stream_decoder_core verification failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/b64d_pkg.sv
rtl/b64d_in_stage.sv
rtl/b64d_decode.sv
rtl/b64d_out_stage.sv
rtl/base64_stream_decoder_core.sv
rtl/b64d_checker.sv
verif/base64_stream_decoder_core_test.sv
